// File: hw/rtl/lmb_pkg.sv
// shared types and constants for the level meter ballistics block
package lmb_pkg;

  localparam int LVL_W = 16;
  localparam logic signed [LVL_W-1:0] LVL_RESET = -16'sd20480;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_ATTACK  = 3'd0;
  localparam logic [2:0] REG_RELEASE = 3'd1;
  localparam logic [2:0] REG_HOLD    = 3'd2;
  localparam logic [2:0] REG_DECAY   = 3'd3;
  localparam logic [2:0] REG_FLOOR   = 3'd4;

  localparam logic [8:0]  ATTACK_RESET  = 9'd154;
  localparam logic [8:0]  RELEASE_RESET = 9'd20;
  localparam logic [15:0] HOLD_RESET    = 16'd60;
  localparam logic [11:0] DECAY_RESET   = 12'd21;
  localparam logic [12:0] FLOOR_RESET   = 13'd1280;

  localparam logic REQ_LEVEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [LVL_W-1:0] left_in;
    logic signed [LVL_W-1:0] right_in;
  } req_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] left_level;
    logic signed [LVL_W-1:0] right_level;
    logic signed [LVL_W-1:0] left_peak;
    logic signed [LVL_W-1:0] right_peak;
  } rsp_t;

endpackage

// File: hw/rtl/level_meter_ballistics.sv
// stereo level meter ballistics: smoothing, peak hold and peak decay
//
//  port group   direction  handshake               payload
//  req          in         req_valid / req_stall   lmb_pkg::req_t
//  rsp          out        rsp_valid / rsp_stall   lmb_pkg::rsp_t
//  apb          in         psel / penable / pready paddr, pwdata, prdata
//
//  one transfer per cycle sustained while rsp is not stalled; an item reaches rsp via the result register
//  one input register, per channel multiply and saturate, one result register
//  the channel state updates as the item leaves the input register
//  a stalled rsp fills the input register, then raises req_stall
//  rst clears both stages, levels and peaks to -80 dB, hold counters to zero
module level_meter_ballistics (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  lmb_pkg::req_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output lmb_pkg::rsp_t       rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef struct packed {
    logic signed [15:0] level;
    logic signed [15:0] peak;
    logic [15:0]        cnt;
  } chan_t;

  logic [8:0]  attack_coef;
  logic [8:0]  release_coef;
  logic [15:0] hold_ticks;
  logic [11:0] decay_per_tick;
  logic [12:0] floor_offset;

  logic          s1_valid;
  lmb_pkg::req_t s1;
  logic          adv;
  logic          cfg_wr;

  chan_t left_st, right_st;
  chan_t left_next, right_next;

  function automatic logic signed [15:0] sat16(logic signed [18:0] v);
    if (v < -19'sd32768) return -16'sd32768;
    else if (v > 19'sd32767) return 16'sd32767;
    else return v[15:0];
  endfunction

  function automatic chan_t smooth_step(logic signed [15:0] x, chan_t st, logic [8:0] atk,
                                        logic [8:0] rel, logic [15:0] hold);
    logic signed [16:0] diff;
    logic [8:0]         coef;
    logic signed [26:0] prod;
    logic signed [18:0] sum;
    chan_t              r;
    diff = {x[15], x} - {st.level[15], st.level};
    coef = (x > st.level) ? atk : rel;
    prod = $signed({1'b0, coef}) * diff;
    sum  = {{3{st.level[15]}}, st.level} + prod[26:8];
    r = st;
    r.level = sat16(sum);
    if (r.level > st.peak) begin
      r.peak = r.level;
      r.cnt  = hold;
    end
    return r;
  endfunction

  function automatic chan_t tick_step(chan_t st, logic [11:0] decay, logic [12:0] flo);
    logic signed [18:0] dec_v;
    logic signed [18:0] low_v;
    logic signed [15:0] pk;
    logic signed [15:0] lo;
    chan_t              r;
    r = st;
    dec_v = {{3{st.peak[15]}}, st.peak} - {7'd0, decay};
    low_v = {{3{st.level[15]}}, st.level} - {6'd0, flo};
    pk = sat16(dec_v);
    lo = sat16(low_v);
    if (st.cnt != 16'd0) begin
      r.cnt = st.cnt - 16'd1;
    end else begin
      r.peak = (pk < lo) ? lo : pk;
    end
    return r;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coef    <= lmb_pkg::ATTACK_RESET;
      release_coef   <= lmb_pkg::RELEASE_RESET;
      hold_ticks     <= lmb_pkg::HOLD_RESET;
      decay_per_tick <= lmb_pkg::DECAY_RESET;
      floor_offset   <= lmb_pkg::FLOOR_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        lmb_pkg::REG_ATTACK:  attack_coef    <= pwdata[8:0];
        lmb_pkg::REG_RELEASE: release_coef   <= pwdata[8:0];
        lmb_pkg::REG_HOLD:    hold_ticks     <= pwdata[15:0];
        lmb_pkg::REG_DECAY:   decay_per_tick <= pwdata[11:0];
        lmb_pkg::REG_FLOOR:   floor_offset   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      lmb_pkg::REG_ATTACK:  prdata = {23'd0, attack_coef};
      lmb_pkg::REG_RELEASE: prdata = {23'd0, release_coef};
      lmb_pkg::REG_HOLD:    prdata = {16'd0, hold_ticks};
      lmb_pkg::REG_DECAY:   prdata = {20'd0, decay_per_tick};
      lmb_pkg::REG_FLOOR:   prdata = {19'd0, floor_offset};
      default:              prdata = 32'd0;
    endcase
  end

  // input register
  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req;
    end
  end

  // per channel update
  always_comb begin
    if (s1.req_type == lmb_pkg::REQ_TICK) begin
      left_next  = tick_step(left_st, decay_per_tick, floor_offset);
      right_next = tick_step(right_st, decay_per_tick, floor_offset);
    end else begin
      left_next  = smooth_step(s1.left_in, left_st, attack_coef, release_coef, hold_ticks);
      right_next = smooth_step(s1.right_in, right_st, attack_coef, release_coef, hold_ticks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_st  <= '{level: lmb_pkg::LVL_RESET, peak: lmb_pkg::LVL_RESET, cnt: 16'd0};
      right_st <= '{level: lmb_pkg::LVL_RESET, peak: lmb_pkg::LVL_RESET, cnt: 16'd0};
    end else if (adv) begin
      left_st  <= left_next;
      right_st <= right_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.left_level  <= left_next.level;
      rsp.right_level <= right_next.level;
      rsp.left_peak   <= left_next.peak;
      rsp.right_peak  <= right_next.peak;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("req_stall raised with room in the pipeline");

  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp_valid)
    else $error("advanced item did not reach the result register");

  a_peak_above_level: assert property (@(posedge clk) disable iff (rst)
    adv && s1.req_type == lmb_pkg::REQ_LEVEL |=>
      left_st.peak >= left_st.level && right_st.peak >= right_st.level)
    else $error("peak below smoothed level after a level item");

  a_hold_freezes_peak: assert property (@(posedge clk) disable iff (rst)
    adv && s1.req_type == lmb_pkg::REQ_TICK && left_st.cnt != 16'd0 |=>
      $stable(left_st.peak))
    else $error("left peak moved while held");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    adv |=> rsp.left_peak == left_st.peak && rsp.right_level == right_st.level)
    else $error("result register out of step with channel state");

endmodule

// File: test/tb.sv
// testbench for level_meter_ballistics: directed and random level and tick transfers
module tb;

  localparam int WATCHDOG_LIMIT = 1000;

  logic          clk;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  lmb_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  lmb_pkg::rsp_t rsp;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [4:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  level_meter_ballistics i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // meter configuration and channel state as the block should hold them
  logic [8:0]  cfg_attack  = lmb_pkg::ATTACK_RESET;
  logic [8:0]  cfg_release = lmb_pkg::RELEASE_RESET;
  logic [15:0] cfg_hold    = lmb_pkg::HOLD_RESET;
  logic [11:0] cfg_decay   = lmb_pkg::DECAY_RESET;
  logic [12:0] cfg_floor   = lmb_pkg::FLOOR_RESET;
  int smooth_l = lmb_pkg::LVL_RESET;
  int smooth_r = lmb_pkg::LVL_RESET;
  int peak_l = lmb_pkg::LVL_RESET;
  int peak_r = lmb_pkg::LVL_RESET;
  int hold_l = 0;
  int hold_r = 0;

  lmb_pkg::rsp_t pending_readings[$];
  int   errors = 0;
  int   burst_left = 0;
  bit   send_gaps = 1'b0;
  bit   rsp_stalls = 1'b0;
  int   stall_run = 0;
  bit   stall_now = 1'b0;
  int   idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp16(input int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  task automatic follow_level(input int x, inout int lvl, inout int pk, inout int cnt);
    int coef;
    int prod;
    coef = (x > lvl) ? int'(cfg_attack) : int'(cfg_release);
    prod = coef * (x - lvl);
    lvl = clamp16(lvl + (prod >>> 8));
    if (lvl > pk) begin
      pk = lvl;
      cnt = cfg_hold;
    end
  endtask

  task automatic age_peak(input int lvl, inout int pk, inout int cnt);
    int low;
    if (cnt > 0) begin
      cnt = cnt - 1;
    end else begin
      low = clamp16(lvl - int'(cfg_floor));
      pk = clamp16(pk - int'(cfg_decay));
      if (pk < low) pk = low;
    end
  endtask

  task automatic predict_reading(input lmb_pkg::req_t item);
    lmb_pkg::rsp_t r;
    if (item.req_type == lmb_pkg::REQ_LEVEL) begin
      follow_level(int'($signed(item.left_in)), smooth_l, peak_l, hold_l);
      follow_level(int'($signed(item.right_in)), smooth_r, peak_r, hold_r);
    end else begin
      age_peak(smooth_l, peak_l, hold_l);
      age_peak(smooth_r, peak_r, hold_r);
    end
    r.left_level  = smooth_l[15:0];
    r.right_level = smooth_r[15:0];
    r.left_peak   = peak_l[15:0];
    r.right_peak  = peak_r[15:0];
    pending_readings.push_back(r);
  endtask

  task automatic send_item(input lmb_pkg::req_t item);
    int gap;
    if (burst_left == 0) begin
      gap = send_gaps ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_reading(item);
  endtask

  function automatic lmb_pkg::req_t make_item(input logic kind, input int left, input int right);
    lmb_pkg::req_t item;
    item.req_type = kind;
    item.left_in  = left[15:0];
    item.right_in = right[15:0];
    return item;
  endfunction

  function automatic int random_level();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 22000) - 24000;
  endfunction

  // drop valid and let every outstanding reading come back
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [31:0] got;
    logic [31:0] want;
    logic [31:0] mask;
    case (idx)
      lmb_pkg::REG_ATTACK:  begin want = cfg_attack;  mask = 32'h1FF;  end
      lmb_pkg::REG_RELEASE: begin want = cfg_release; mask = 32'h1FF;  end
      lmb_pkg::REG_HOLD:    begin want = cfg_hold;    mask = 32'hFFFF; end
      lmb_pkg::REG_DECAY:   begin want = cfg_decay;   mask = 32'hFFF;  end
      default:              begin want = cfg_floor;   mask = 32'h1FFF; end
    endcase
    apb_access(1'b0, idx, '0, got);
    if ((got & mask) !== want) begin
      $display("%0t: register %0d expected %0d got %0d", $time, idx, want, got & mask);
      errors++;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      lmb_pkg::REG_ATTACK:  cfg_attack  = value[8:0];
      lmb_pkg::REG_RELEASE: cfg_release = value[8:0];
      lmb_pkg::REG_HOLD:    cfg_hold    = value[15:0];
      lmb_pkg::REG_DECAY:   cfg_decay   = value[11:0];
      default:              cfg_floor   = value[12:0];
    endcase
    check_reg(idx);
  endtask

  task automatic set_config(input logic [31:0] attack, input logic [31:0] rel,
                            input logic [31:0] hold, input logic [31:0] decay,
                            input logic [31:0] floor_off);
    settle();
    write_reg(lmb_pkg::REG_ATTACK, attack);
    write_reg(lmb_pkg::REG_RELEASE, rel);
    write_reg(lmb_pkg::REG_HOLD, hold);
    write_reg(lmb_pkg::REG_DECAY, decay);
    write_reg(lmb_pkg::REG_FLOOR, floor_off);
  endtask

  task automatic run_phase(input int count, input int tick_pct);
    repeat (count) begin
      send_item(make_item(($urandom_range(0, 99) < tick_pct) ? lmb_pkg::REQ_TICK
                                                              : lmb_pkg::REQ_LEVEL,
                          random_level(), random_level()));
    end
  endtask

  task automatic test_registers();
    check_reg(lmb_pkg::REG_ATTACK);
    check_reg(lmb_pkg::REG_RELEASE);
    check_reg(lmb_pkg::REG_HOLD);
    check_reg(lmb_pkg::REG_DECAY);
    check_reg(lmb_pkg::REG_FLOOR);
    set_config('1, '1, '1, '1, '1);
    set_config('0, '0, '0, '0, '0);
    set_config(lmb_pkg::ATTACK_RESET, lmb_pkg::RELEASE_RESET, lmb_pkg::HOLD_RESET,
               lmb_pkg::DECAY_RESET, lmb_pkg::FLOOR_RESET);
  endtask

  task automatic test_default_ballistics();
    send_item(make_item(lmb_pkg::REQ_LEVEL, 32767, -32768));
    send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
    send_item(make_item(lmb_pkg::REQ_TICK, -1, -1));
    send_item(make_item(lmb_pkg::REQ_LEVEL, -32768, 32767));
    send_item(make_item(lmb_pkg::REQ_LEVEL, smooth_l, smooth_r));
    send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
  endtask

  task automatic test_saturation_and_floor();
    set_config(0, 256, 0, 4095, 8191);
    send_item(make_item(lmb_pkg::REQ_LEVEL, -32768, -32768));
    repeat (4) send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
    set_config(511, 1, 0, 4095, 8191);
    send_item(make_item(lmb_pkg::REQ_LEVEL, 32767, 0));
    send_item(make_item(lmb_pkg::REQ_LEVEL, smooth_l, smooth_r));
    // third tick pulls the peak back up to level minus floor offset
    repeat (3) send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
    set_config(511, 1, 0, 4095, 0);
    send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
  endtask

  task automatic test_hold_equal_level();
    set_config(lmb_pkg::ATTACK_RESET, lmb_pkg::RELEASE_RESET, 2, lmb_pkg::DECAY_RESET,
               lmb_pkg::FLOOR_RESET);
    send_item(make_item(lmb_pkg::REQ_LEVEL, 0, -1000));
    send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
    // level item equal to the smoothed level must not reload the hold count
    send_item(make_item(lmb_pkg::REQ_LEVEL, smooth_l, smooth_r));
    send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
    send_item(make_item(lmb_pkg::REQ_TICK, 0, 0));
  endtask

  task automatic test_random_traffic();
    set_config(lmb_pkg::ATTACK_RESET, lmb_pkg::RELEASE_RESET, lmb_pkg::HOLD_RESET,
               lmb_pkg::DECAY_RESET, lmb_pkg::FLOOR_RESET);
    send_gaps = 1'b1;
    rsp_stalls = 1'b1;
    run_phase(100, 60);
    set_config('0, '0, '0, '0, '0);
    send_gaps = 1'b0;
    rsp_stalls = 1'b0;
    run_phase(50, 50);
    set_config('1, '1, '1, '1, '1);
    send_gaps = 1'b1;
    run_phase(50, 50);
    repeat (6) begin
      set_config($urandom(), $urandom(), ($urandom() & 32'hFFFF0000) | $urandom_range(0, 6),
                 $urandom(), $urandom());
      send_gaps = $urandom_range(0, 1);
      rsp_stalls = $urandom_range(0, 1);
      run_phase(70, 50);
    end
  endtask

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_now = rsp_stalls && ($urandom_range(0, 2) == 0);
      stall_run = $urandom_range(1, stall_now ? 8 : 6);
    end
    stall_run--;
    rsp_stall <= stall_now;
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_readings
    lmb_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading %h", $time, rsp);
        errors++;
      end else begin
        want = pending_readings.pop_front();
        check_field("left_level", want.left_level, rsp.left_level);
        check_field("right_level", want.right_level, rsp.right_level);
        check_field("left_peak", want.left_peak, rsp.left_peak);
        check_field("right_peak", want.right_peak, rsp.right_peak);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_registers();
    test_default_ballistics();
    test_saturation_and_floor();
    test_hold_equal_level();
    test_random_traffic();
    settle();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: level_meter_ballistics.f
hw/rtl/lmb_pkg.sv
hw/rtl/level_meter_ballistics.sv
test/tb.sv
